### rtl/stws_pkg.sv
package stws_pkg;

  // fixed widths of the item fields and registers
  localparam int unsigned FieldW = 30;
  localparam int unsigned TapW   = 4;
  localparam int unsigned RunW   = 5;
  localparam int unsigned CfgW   = 5;

  typedef enum logic {
    CFG_TAP_COUNT = 1'b0,
    CFG_MIN_RUN   = 1'b1
  } cfg_idx_e;

  // a run candidate: its length and the probe where it starts
  typedef struct packed {
    logic [RunW-1:0] len;
    logic [RunW-1:0] start;
  } best_t;

  // lo comes from the lower probe index, so it wins ties
  function automatic best_t pick_best(best_t lo, best_t hi);
    pick_best = (hi.len > lo.len) ? hi : lo;
  endfunction

endpackage

### rtl/sample_tap_window_select_top.sv
// sampling tap window select
// s_axis carries one item per probe sweep: pass and match vectors of 2*N probes.
// m_axis returns one item per input: the chosen tap, with tuser set on failure.
// the config port writes tap_count (index 0) and min_run (index 1); the user
// must write them only while idle, since the block itself has no check for it.
// pipeline of five register stages: pair merge, per-probe run length, two
// levels of a registered max tree, then run selection and tap wrap.
// throughput is one item per cycle while the receiver takes items; every stage
// holds its own valid bit. a stalled receiver holds the output item; upstream
// stages keep filling their empty slots and s_axis_tready_o drops only once
// all five are full.
// reset empties the pipeline and loads tap_count 8 and min_run 3.
// PROBE_WIDTH caps the probe window; windows longer than 30 probes are
// never needed since the tap count tops out at 15.
module sample_tap_window_select_top #(
  parameter int unsigned PROBE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,    // pass_bits[29:0], match_bits[59:30]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,    // tap_position[3:0]
  output logic        m_axis_tuser_o,    // failed
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i
);
  import stws_pkg::*;

  localparam int unsigned VecW = (PROBE_WIDTH < FieldW) ? PROBE_WIDTH : FieldW;
  localparam int unsigned Grp  = 4;
  localparam int unsigned Mid  = (VecW + Grp - 1) / Grp;

  logic [TapW-1:0] tap_count_q;
  logic [RunW-1:0] min_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TapW'(8);
      min_run_q   <= RunW'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TAP_COUNT: tap_count_q <= cfg_data_i[TapW-1:0];
        CFG_MIN_RUN:   min_run_q   <= cfg_data_i[RunW-1:0];
        default:       ;
      endcase
    end
  end

  logic            mg_valid, mg_ready;
  logic [VecW-1:0] mg_pass, mg_match;
  logic            rl_valid, rl_ready;
  best_t [VecW-1:0] rl_pass, rl_match;
  logic            t1_valid, t1_ready;
  best_t [Mid-1:0] t1_pass, t1_match;
  logic            t2_valid, t2_ready;
  best_t [0:0]     t2_pass, t2_match;
  logic [TapW-1:0] tap_position;

  stws_merge #(.VecW(VecW)) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid_i),
    .ready_o    (s_axis_tready_o),
    .pass_i     (s_axis_tdata_i[FieldW-1:0]),
    .match_i    (s_axis_tdata_i[2*FieldW-1:FieldW]),
    .tap_count_i(tap_count_q),
    .valid_o    (mg_valid),
    .ready_i    (mg_ready),
    .pass_o     (mg_pass),
    .match_o    (mg_match)
  );

  stws_runlen #(.VecW(VecW)) u_runlen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(mg_valid),
    .ready_o(mg_ready),
    .pass_i (mg_pass),
    .match_i(mg_match),
    .valid_o(rl_valid),
    .ready_i(rl_ready),
    .pass_o (rl_pass),
    .match_o(rl_match)
  );

  stws_maxtree #(.NumIn(VecW), .Group(Grp)) u_tree_lo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(rl_valid),
    .ready_o(rl_ready),
    .pass_i (rl_pass),
    .match_i(rl_match),
    .valid_o(t1_valid),
    .ready_i(t1_ready),
    .pass_o (t1_pass),
    .match_o(t1_match)
  );

  stws_maxtree #(.NumIn(Mid), .Group(Mid)) u_tree_hi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(t1_valid),
    .ready_o(t1_ready),
    .pass_i (t1_pass),
    .match_i(t1_match),
    .valid_o(t2_valid),
    .ready_i(t2_ready),
    .pass_o (t2_pass),
    .match_o(t2_match)
  );

  stws_decide u_decide (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (t2_valid),
    .ready_o       (t2_ready),
    .pass_i        (t2_pass[0]),
    .match_i       (t2_match[0]),
    .tap_count_i   (tap_count_q),
    .min_run_i     (min_run_q),
    .valid_o       (m_axis_tvalid_o),
    .ready_i       (m_axis_tready_i),
    .tap_position_o(tap_position),
    .failed_o      (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {(8 - TapW)'(0), tap_position};

endmodule

### rtl/stws_merge.sv
module stws_merge #(
  parameter int unsigned VecW = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [stws_pkg::FieldW-1:0]   pass_i,
  input  logic [stws_pkg::FieldW-1:0]   match_i,
  input  logic [stws_pkg::TapW-1:0]     tap_count_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [VecW-1:0]               pass_o,
  output logic [VecW-1:0]               match_o
);
  import stws_pkg::*;

  logic [RunW-1:0] two_n;
  logic [RunW-1:0] win_len;
  logic [VecW-1:0] mask;
  logic [VecW-1:0] pass_d, match_d;
  logic [VecW-1:0] pass_q, match_q;
  logic            valid_q;

  function automatic logic [VecW-1:0] merge_vec(logic [VecW-1:0] v, logic [TapW-1:0] n,
                                                logic [RunW-1:0] len);
    logic [VecW-1:0] up, dn, r;
    up = v >> n;
    dn = v << n;
    for (int i = 0; i < VecW; i++) begin
      if (i < int'(n)) begin
        // partner above the window counts as passing
        r[i] = v[i] & (up[i] | ((i + int'(n)) >= int'(len)));
      end else begin
        r[i] = v[i] & dn[i];
      end
    end
    return r;
  endfunction

  always_comb begin
    two_n   = {1'b0, tap_count_i} << 1;
    win_len = (int'(two_n) > VecW) ? RunW'(VecW) : two_n;
    for (int i = 0; i < VecW; i++) begin
      mask[i] = (i < int'(win_len));
    end
    pass_d  = merge_vec(pass_i[VecW-1:0] & mask, tap_count_i, win_len);
    match_d = merge_vec(match_i[VecW-1:0] & mask, tap_count_i, win_len);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pass_q  <= pass_d;
      match_q <= match_d;
    end
  end

  assign valid_o = valid_q;
  assign pass_o  = pass_q;
  assign match_o = match_q;

endmodule

### rtl/stws_runlen.sv
module stws_runlen #(
  parameter int unsigned VecW = 30
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic [VecW-1:0]                    pass_i,
  input  logic [VecW-1:0]                    match_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output stws_pkg::best_t [VecW-1:0]         pass_o,
  output stws_pkg::best_t [VecW-1:0]         match_o
);
  import stws_pkg::*;

  best_t [VecW-1:0] pass_d, match_d;
  best_t [VecW-1:0] pass_q, match_q;
  logic             valid_q;

  // number of consecutive ones starting at probe s
  function automatic logic [RunW-1:0] ones_from(logic [VecW-1:0] v, int s);
    logic [VecW-1:0] w;
    logic [RunW-1:0] cnt;
    w   = v >> s;
    cnt = RunW'(VecW);
    for (int k = VecW - 1; k >= 0; k--) begin
      if (!w[k]) cnt = RunW'(k);
    end
    return cnt;
  endfunction

  always_comb begin
    for (int s = 0; s < VecW; s++) begin
      pass_d[s].len    = ones_from(pass_i, s);
      pass_d[s].start  = RunW'(s);
      match_d[s].len   = ones_from(match_i, s);
      match_d[s].start = RunW'(s);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pass_q  <= pass_d;
      match_q <= match_d;
    end
  end

  assign valid_o = valid_q;
  assign pass_o  = pass_q;
  assign match_o = match_q;

endmodule

### rtl/stws_maxtree.sv
module stws_maxtree #(
  parameter int unsigned NumIn = 30,
  parameter int unsigned Group = 4,
  localparam int unsigned NumOut = (NumIn + Group - 1) / Group
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  stws_pkg::best_t [NumIn-1:0]        pass_i,
  input  stws_pkg::best_t [NumIn-1:0]        match_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output stws_pkg::best_t [NumOut-1:0]       pass_o,
  output stws_pkg::best_t [NumOut-1:0]       match_o
);
  import stws_pkg::*;

  best_t [NumOut-1:0] pass_d, match_d;
  best_t [NumOut-1:0] pass_q, match_q;
  logic               valid_q;

  // fold each group from its lowest index up so ties keep the first run
  always_comb begin
    for (int g = 0; g < NumOut; g++) begin
      pass_d[g]  = pass_i[g * Group];
      match_d[g] = match_i[g * Group];
      for (int k = 1; k < Group; k++) begin
        if (g * Group + k < NumIn) begin
          pass_d[g]  = pick_best(pass_d[g], pass_i[g * Group + k]);
          match_d[g] = pick_best(match_d[g], match_i[g * Group + k]);
        end
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pass_q  <= pass_d;
      match_q <= match_d;
    end
  end

  assign valid_o = valid_q;
  assign pass_o  = pass_q;
  assign match_o = match_q;

endmodule

### rtl/stws_decide.sv
module stws_decide (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  stws_pkg::best_t               pass_i,
  input  stws_pkg::best_t               match_i,
  input  logic [stws_pkg::TapW-1:0]     tap_count_i,
  input  logic [stws_pkg::RunW-1:0]     min_run_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [stws_pkg::TapW-1:0]     tap_position_o,
  output logic                          failed_o
);
  import stws_pkg::*;

  logic            all_pass;
  logic            ok;
  best_t           sel;
  logic [RunW-1:0] half;
  logic [RunW-1:0] center;
  logic [RunW-1:0] n_ext;
  logic [RunW-1:0] wrapped;
  logic [TapW-1:0] pos_d, pos_q;
  logic            failed_d, failed_q;
  logic            valid_q;

  always_comb begin
    n_ext    = {1'b0, tap_count_i};
    all_pass = (pass_i.len == (n_ext << 1));
    sel      = all_pass ? match_i : pass_i;
    if (tap_count_i == '0) begin
      ok = 1'b0;
    end else if (all_pass) begin
      ok = (match_i.len != '0);
    end else begin
      ok = (pass_i.len >= min_run_i);
    end
    // empty run has start and end both zero
    half     = (sel.len == '0) ? '0 : ((sel.len - RunW'(1)) >> 1);
    center   = sel.start + half;
    // center stays below twice the tap count
    wrapped  = (center >= n_ext) ? (center - n_ext) : center;
    pos_d    = ok ? wrapped[TapW-1:0] : '0;
    failed_d = !ok;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pos_q    <= pos_d;
      failed_q <= failed_d;
    end
  end

  assign valid_o        = valid_q;
  assign tap_position_o = pos_q;
  assign failed_o       = failed_q;

endmodule
